// ----- src/tem_pkg.sv -----
// shared constants, types and codes of the throughput meter
// no dependencies; used by every other file of the block
`default_nettype none
package tem_pkg;
	localparam int DECAY_FRAC_BITS = 16;
	localparam int TIME_W = 40;
	localparam int BYTE_W = 48;
	localparam int DECAY_W = 32;
	localparam int NUM_W = 72;
	localparam int DEN_W = 40;
	localparam int STEP_W = 7;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int SCALED_W = BYTE_W + 18;
	localparam int SERIES_TERMS = 20;
	localparam logic [MUL_B_W-1:0] EXP_M1_Q32 = 32'd1580030169;
	localparam logic [BYTE_W-1:0] RATE_MAX = {BYTE_W{1'b1}};
	localparam logic [DECAY_W-1:0] DECAY_RESET = 32'd3600000;

	// register indexes
	localparam logic REG_SEED = 1'b0;
	localparam logic REG_DECAY = 1'b1;

	// item kinds
	localparam logic ACT_POLL = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	typedef struct packed {
		logic start;
		logic [STEP_W-1:0] steps;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

// ----- src/tem_if.sv -----
// channel interfaces of the throughput meter: input, result and register write
// depends on tem_pkg
`default_nettype none
interface tem_in_if import tem_pkg::*; ();
	logic valid;
	logic ready;
	logic action;
	logic [TIME_W-1:0] now_ms;
	logic [BYTE_W-1:0] byte_count;
	logic active;
	modport source (output valid, action, now_ms, byte_count, active, input ready);
	modport sink (input valid, action, now_ms, byte_count, active, output ready);
endinterface

interface tem_out_if import tem_pkg::*; ();
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] rate_estimate;
	modport source (output valid, rate_estimate, input ready);
	modport sink (input valid, rate_estimate, output ready);
endinterface

interface tem_cfg_if import tem_pkg::*; ();
	logic valid;
	logic ready;
	logic index;
	logic [BYTE_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/throughput_ema_meter.sv -----
// channel   | dir | handshake      | payload
// in_ch     | in  | valid / ready  | action, now_ms, byte_count, active
// out_ch    | out | valid / ready  | rate_estimate
// cfg       | in  | valid / ready  | index, data
// A poll item is handled in the idle state; a report with no accumulated time goes
// straight to the done state. A full report runs the shared divider and the shared
// multiplier (20 + up to 31 + 4 products). in_ch is not ready during a report or
// while a result waits on out_ch. Reset is asynchronous; it sets the default decay,
// clears other meter state, but not divider or multiplier data; cfg is always ready.
// depends on tem_pkg, tem_if, tem_div, tem_mul
`default_nettype none
module throughput_ema_meter import tem_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	tem_in_if.sink in_ch,
	tem_out_if.source out_ch,
	tem_cfg_if.sink cfg
);
	localparam int F = DECAY_FRAC_BITS;
	localparam int HALF = BYTE_W / 2;
	localparam int PART_W = BYTE_W + F + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RAW, S_EXP, S_SMUL, S_SDIV, S_POW, S_BLEND, S_DONE
	} state_t;

	state_t state_q;
	logic [TIME_W-1:0] prev_time_q;
	logic [BYTE_W-1:0] prev_bytes_q;
	logic [TIME_W-1:0] el_q;
	logic [BYTE_W-1:0] by_q;
	logic [BYTE_W-1:0] est_q;
	logic consumed_q;
	logic [BYTE_W-1:0] seed_q;
	logic [DECAY_W-1:0] decay_q;
	logic [BYTE_W-1:0] prev_q;
	logic [BYTE_W-1:0] raw_q;
	logic [BYTE_W-1:0] result_q;
	logic [31:0] f_q;
	logic [33:0] sum_q;
	logic [32:0] term_q;
	logic [4:0] k_q;
	logic [4:0] pw_q;
	logic big_q;
	logic ph_q;
	logic [1:0] bs_q;
	logic [PART_W-1:0] part_q;
	logic [BYTE_W:0] tot_q;
	logic out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	div_req_t div_req_q;
	div_rsp_t div_rsp;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;

	// poll arithmetic
	logic [TIME_W-1:0] dt;
	logic [TIME_W:0] el_sum;
	logic [BYTE_W-1:0] db;
	logic [BYTE_W:0] by_sum;
	logic [SCALED_W-1:0] scaled;
	logic [BYTE_W-1:0] prev_pick;
	logic [BYTE_W-1:0] raw_sat;
	logic [33:0] ser_next;
	logic [33:0] ser_clamp;
	logic [F:0] x_w;
	logic [F:0] w_now;
	logic [BYTE_W-1:0] v_now;
	logic [PART_W-1:0] part_full;

	assign dt = (prev_time_q != '0 && in_ch.now_ms >= prev_time_q) ?
		in_ch.now_ms - prev_time_q : '0;
	assign el_sum = {1'b0, el_q} + {1'b0, dt};
	assign db = in_ch.byte_count - prev_bytes_q;
	assign by_sum = {1'b0, by_q} + {1'b0, db};
	// bytes * 256000 as bytes * (2^18 - 2^12 - 2^11)
	assign scaled = (SCALED_W'(by_q) << 18) - (SCALED_W'(by_q) << 12) -
		(SCALED_W'(by_q) << 11);
	assign prev_pick = consumed_q ? est_q : seed_q;
	assign raw_sat = (div_rsp.quot[NUM_W-1:BYTE_W] != '0) ? RATE_MAX :
		div_rsp.quot[BYTE_W-1:0];

	// series step: odd terms subtract, even terms add, clamp after the last
	always_comb begin
		if (k_q[0])
			ser_next = ({1'b0, div_rsp.quot[32:0]} > sum_q) ? '0 :
				sum_q - {1'b0, div_rsp.quot[32:0]};
		else
			ser_next = sum_q + {1'b0, div_rsp.quot[32:0]};
		ser_clamp = (ser_next > 34'h1_0000_0000) ? 34'h1_0000_0000 : ser_next;
	end

	// blend weights and operands
	assign x_w = sum_q[32:32-F];
	assign w_now = bs_q[1] ? (F+1)'((1 << F) - x_w) : x_w;
	assign v_now = bs_q[1] ? raw_q : prev_q;
	assign part_full = part_q + (PART_W'(prod) << HALF);

	// multiplier operand select
	always_comb begin
		case (state_q)
			S_SMUL: begin
				mul_a = term_q;
				mul_b = f_q;
			end
			S_POW: begin
				mul_a = sum_q[32:0];
				mul_b = EXP_M1_Q32;
			end
			S_BLEND: begin
				mul_a = MUL_A_W'(w_now);
				mul_b = bs_q[0] ? MUL_B_W'(v_now[BYTE_W-1:HALF]) :
					MUL_B_W'(v_now[HALF-1:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	tem_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .rsp(div_rsp));
	tem_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	// sequencer with its state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_time_q <= '0;
			prev_bytes_q <= '0;
			el_q <= '0;
			by_q <= '0;
			est_q <= '0;
			consumed_q <= 1'b0;
			seed_q <= '0;
			decay_q <= DECAY_RESET;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			div_req_q <= '0;
			ph_q <= 1'b0;
			bs_q <= '0;
			k_q <= '0;
			pw_q <= '0;
			big_q <= 1'b0;
			prev_q <= '0;
			raw_q <= '0;
			result_q <= '0;
			f_q <= '0;
			sum_q <= '0;
			term_q <= '0;
			part_q <= '0;
			tot_q <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			// register writes
			if (cfg.valid) begin
				if (cfg.index == REG_SEED)
					seed_q <= cfg.data;
				else if (cfg.index == REG_DECAY)
					decay_q <= (cfg.data[DECAY_W-1:0] == '0) ? DECAY_W'(1) :
						cfg.data[DECAY_W-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.action == ACT_POLL) begin
							prev_time_q <= in_ch.now_ms;
							prev_bytes_q <= in_ch.byte_count;
							if (in_ch.active) begin
								el_q <= el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
								by_q <= by_sum[BYTE_W] ? '1 : by_sum[BYTE_W-1:0];
							end
						end else begin
							prev_q <= prev_pick;
							if (el_q == '0) begin
								result_q <= prev_pick;
								state_q <= S_DONE;
							end else begin
								div_req_q.start <= 1'b1;
								div_req_q.steps <= STEP_W'(SCALED_W);
								div_req_q.num <= {scaled, (NUM_W-SCALED_W)'(0)};
								div_req_q.den <= el_q;
								state_q <= S_RAW;
							end
						end
					end
				end
				S_RAW: begin
					if (div_rsp.done) begin
						raw_q <= raw_sat;
						if (prev_q == '0) begin
							result_q <= raw_sat;
							state_q <= S_DONE;
						end else begin
							div_req_q.start <= 1'b1;
							div_req_q.steps <= STEP_W'(NUM_W);
							div_req_q.num <= {el_q, 32'd0};
							div_req_q.den <= DEN_W'(decay_q);
							state_q <= S_EXP;
						end
					end
				end
				S_EXP: begin
					if (div_rsp.done) begin
						f_q <= div_rsp.quot[31:0];
						big_q <= div_rsp.quot[NUM_W-1:37] != '0;
						pw_q <= div_rsp.quot[36:32];
						sum_q <= 34'h1_0000_0000;
						term_q <= 33'h1_0000_0000;
						k_q <= 5'd1;
						ph_q <= 1'b0;
						state_q <= S_SMUL;
					end
				end
				S_SMUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						div_req_q.start <= 1'b1;
						div_req_q.steps <= STEP_W'(33);
						div_req_q.num <= {prod[PROD_W-1:32], (NUM_W-33)'(0)};
						div_req_q.den <= DEN_W'(k_q);
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_rsp.done) begin
						term_q <= div_rsp.quot[32:0];
						ph_q <= 1'b0;
						bs_q <= '0;
						tot_q <= '0;
						if (k_q == 5'(SERIES_TERMS)) begin
							if (big_q) begin
								sum_q <= '0;
								state_q <= S_BLEND;
							end else begin
								sum_q <= ser_clamp;
								state_q <= (pw_q == '0) ? S_BLEND : S_POW;
							end
						end else begin
							sum_q <= ser_next;
							k_q <= k_q + 1'b1;
							state_q <= S_SMUL;
						end
					end
				end
				S_POW: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						sum_q <= {1'b0, prod[PROD_W-1:32]};
						pw_q <= pw_q - 1'b1;
						if (pw_q == 5'd1)
							state_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						bs_q <= bs_q + 1'b1;
						if (!bs_q[0]) begin
							part_q <= PART_W'(prod);
						end else begin
							tot_q <= tot_q + (BYTE_W+1)'(part_full >> F);
							if (bs_q[1])
								state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
					out_data_q <= result_q;
					est_q <= result_q;
					consumed_q <= 1'b1;
					el_q <= '0;
					by_q <= '0;
				end
				default: state_q <= S_IDLE;
			endcase
			// blended sum lands in the result on the last blend step, as the state moves to done
			if (state_q == S_BLEND && ph_q && bs_q == 2'd3) begin
				result_q <= (({1'b0, tot_q} + (BYTE_W+2)'(part_full >> F)) >
					(BYTE_W+2)'(RATE_MAX)) ? RATE_MAX :
					BYTE_W'(tot_q + (BYTE_W+1)'(part_full >> F));
			end
		end
	end

	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.rate_estimate = out_data_q;
	assign cfg.ready = 1'b1;

`ifndef SYNTH
	// no item is taken while the divider still works on a report
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !div_rsp.busy) else $error("ready while divider busy");
	// the seed stays retired once a report has been made
	a_seed_gone: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(consumed_q)) else $error("seed flag cleared");
	// a quotient only arrives in a state that waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_RAW || state_q == S_EXP || state_q == S_SDIV))
		else $error("unexpected quotient");
	// a result leaves the done state straight into the output register
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid_q && state_q == S_IDLE)
		else $error("result not posted");
`endif
endmodule
`default_nettype wire

// ----- src/tem_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on tem_pkg
`default_nettype none
module tem_div import tem_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] rem_sh;
	logic fits;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

// ----- src/tem_mul.sv -----
// shared registered multiplier, product in the cycle after the operands
// depends on tem_pkg
`default_nettype none
module tem_mul import tem_pkg::*; (
	input wire logic clk,
	input wire logic [MUL_A_W-1:0] a,
	input wire logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0] prod
);
	logic [PROD_W-1:0] prod_q;

	// product register
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;
endmodule
`default_nettype wire
